[rtl/core/qpht_pkg.sv]
package qpht_pkg;

  // Field widths of the request and response transactions.
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // The home slot is the key minus its quotient by the slot count times that count.
  // The quotient comes from a registered multiply by a fixed-point reciprocal of the
  // slot count.
  localparam int RECIP_W   = 32;
  localparam int MOD_STEPS = 2;
  localparam int MOD_CNT_W = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                clr_wr;
    logic                load;
    logic                mod_step;
    logic                probe_init;
    logic                rd;
    logic                probe_adv;
    logic                wr;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_hit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic key_zero;
    logic op;
    logic rd_empty;
    logic rd_match;
    logic probe_first;
    logic probe_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/core/qpht_req_if.sv]
interface qpht_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [qpht_pkg::KEY_W-1:0]   key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

[rtl/core/qpht_rsp_if.sv]
interface qpht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [qpht_pkg::STATUS_W-1:0] status;
  logic [qpht_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

[rtl/core/qpht_ctrl.sv]
module qpht_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  qpht_pkg::stat_t stat,
  output qpht_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [qpht_pkg::STATUS_W-1:0] res_code;
  logic [qpht_pkg::STATUS_W-1:0] res_code_next;
  logic                          res_hit;
  logic                          res_hit_next;

  assign req_ready = (state == S_IDLE);

  // Sequencing of the clearing pass and of one request.
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    res_hit_next  = res_hit;
    cmd           = '0;
    cmd.res_status = res_code;
    cmd.res_hit    = res_hit;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.key_zero) begin
          res_code_next = qpht_pkg::ST_NOT_FOUND;
          res_hit_next  = 1'b0;
          state_next    = S_RESULT;
        end else begin
          cmd.probe_init = 1'b1;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_RESULT;
        if (stat.op == qpht_pkg::OP_INSERT) begin
          if (stat.rd_empty) begin
            cmd.wr        = 1'b1;
            res_code_next = qpht_pkg::ST_INSERTED;
            res_hit_next  = 1'b1;
          end else if (stat.probe_last) begin
            res_code_next = qpht_pkg::ST_FULL;
            res_hit_next  = 1'b0;
          end else begin
            cmd.probe_adv = 1'b1;
            state_next    = S_READ;
          end
        end else begin
          // An empty home slot ends a search; later empty slots do not.
          if (stat.probe_first && stat.rd_empty) begin
            res_code_next = qpht_pkg::ST_NOT_FOUND;
            res_hit_next  = 1'b0;
          end else if (stat.rd_match) begin
            res_code_next = qpht_pkg::ST_FOUND;
            res_hit_next  = 1'b1;
          end else if (stat.probe_last) begin
            res_code_next = qpht_pkg::ST_NOT_FOUND;
            res_hit_next  = 1'b0;
          end else begin
            cmd.probe_adv = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      res_code <= qpht_pkg::ST_NOT_FOUND;
      res_hit  <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_hit  <= res_hit_next;
    end
  end

endmodule

[rtl/core/qpht_dp.sv]
module qpht_dp #(
  parameter int SLOTS       = 16,
  parameter int PROBE_LIMIT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qpht_pkg::cmd_t                cmd,
  output qpht_pkg::stat_t               stat,
  input  logic                          req_op,
  input  logic [qpht_pkg::KEY_W-1:0]    req_key,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic [qpht_pkg::STATUS_W-1:0] rsp_status,
  output logic [qpht_pkg::SLOT_W-1:0]   rsp_slot
);

  localparam int SW = $clog2(SLOTS);
  localparam int IW = $clog2(PROBE_LIMIT);
  localparam int SH = qpht_pkg::KEY_W + SW;
  localparam int PW = qpht_pkg::KEY_W + qpht_pkg::RECIP_W;
  localparam logic [SW:0] SLOTS_EXT = (SW+1)'(SLOTS);
  localparam logic [qpht_pkg::RECIP_W-1:0] RECIP =
    qpht_pkg::RECIP_W'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

  logic [qpht_pkg::KEY_W-1:0]      mem [SLOTS];
  logic [qpht_pkg::KEY_W-1:0]      rdata;
  logic                            op_q;
  logic [qpht_pkg::KEY_W-1:0]      key_q;
  logic [PW-1:0]                   prod;
  logic [SW-1:0]                   qd_low;
  logic [qpht_pkg::MOD_CNT_W-1:0]  mod_cnt;
  logic [SW-1:0]                   rem;
  logic [SW-1:0]                   idx;
  logic [SW-1:0]                   stride;
  logic [IW-1:0]                   probe_i;
  logic [SW-1:0]                   clr_addr;
  logic [SW:0]                     idx_sum;
  logic [SW:0]                     idx_adv;
  logic [SW:0]                     stride_sum;
  logic [SW:0]                     stride_adv;
  logic [SW+qpht_pkg::SLOT_W-1:0]  slot_ext;

  // The quotient sits in the product bits from SH up; the remainder is below the
  // slot count, so only the low bits of quotient times slot count are needed.
  assign qd_low = prod[SH +: SW] * SW'(SLOTS);

  // Next probe: the slot moves by the odd stride 2i-1, both kept below the slot count.
  always_comb begin
    idx_sum    = {1'b0, idx} + {1'b0, stride};
    idx_adv    = (idx_sum >= SLOTS_EXT) ? (idx_sum - SLOTS_EXT) : idx_sum;
    stride_sum = {1'b0, stride} + (SW+1)'(2);
    stride_adv = (stride_sum >= SLOTS_EXT) ? (stride_sum - SLOTS_EXT) : stride_sum;
  end

  assign slot_ext = (SW+qpht_pkg::SLOT_W)'(idx);

  // Status toward the controller.
  always_comb begin
    stat.clr_done    = (clr_addr == SW'(SLOTS-1));
    stat.mod_done    = (mod_cnt == qpht_pkg::MOD_CNT_W'(qpht_pkg::MOD_STEPS-1));
    stat.key_zero    = (key_q == '0);
    stat.op          = op_q;
    stat.rd_empty    = (rdata == '0);
    stat.rd_match    = (rdata == key_q);
    stat.probe_first = (probe_i == '0);
    stat.probe_last  = (probe_i == IW'(PROBE_LIMIT-1));
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  // Slot store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[idx] <= key_q;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  // Request capture, remainder unit and probe sequence.
  // The first remainder step registers the product, the second forms the remainder.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req_op;
      key_q   <= req_key;
      mod_cnt <= '0;
    end
    if (cmd.mod_step) begin
      prod    <= PW'(key_q) * PW'(RECIP);
      rem     <= key_q[SW-1:0] - qd_low;
      mod_cnt <= mod_cnt + qpht_pkg::MOD_CNT_W'(1);
    end
    if (cmd.probe_init) begin
      idx     <= rem;
      stride  <= SW'(1);
      probe_i <= '0;
    end
    if (cmd.probe_adv) begin
      idx     <= idx_adv[SW-1:0];
      stride  <= stride_adv[SW-1:0];
      probe_i <= probe_i + IW'(1);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status <= cmd.res_status;
      rsp_slot   <= cmd.res_hit ? slot_ext[qpht_pkg::SLOT_W-1:0] : '0;
    end
  end

endmodule

[rtl/core/quadratic_probe_hash_table_unit.sv]
// Channel  Direction  Payload        Transaction
// req      in         op, key        valid && ready at a rising edge
// rsp      out        status, slot   valid && ready at a rising edge
//
// After reset a clearing pass zeroes the store, one slot per cycle.
// A request passes from acceptance to a valid response through the remainder unit,
// the probe setup, one read per probed slot through the registered read port of the
// store (1 to PROBE_LIMIT slots, none for a zero key) and the load of the response
// register.
// A request taken while a response waits holds in its final step until that is taken.
module quadratic_probe_hash_table_unit #(
  parameter int SLOTS       = 16,
  parameter int PROBE_LIMIT = 10
) (
  input  logic       clk,
  input  logic       rst,
  qpht_req_if.sink   req,
  qpht_rsp_if.source rsp
);

  qpht_pkg::cmd_t  cmd;
  qpht_pkg::stat_t stat;

  qpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qpht_dp #(
    .SLOTS       (SLOTS),
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_op     (req.op),
    .req_key    (req.key),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot)
  );

  // No request is taken while the store is being cleared.
  assert property (@(posedge clk) disable iff (rst) cmd.clr_wr |-> !req.ready)
    else $error("request accepted during clearing pass");

  // A key is written only by an insert that found an empty slot.
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (stat.op == qpht_pkg::OP_INSERT) && stat.rd_empty && !stat.key_zero)
    else $error("slot write outside a successful insert");

  // A new response never overwrites one that has not been taken.
  assert property (@(posedge clk) disable iff (rst) cmd.res_load |-> stat.out_free)
    else $error("pending response overwritten");

  // A hit is reported only with an inserted or found status.
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load && cmd.res_hit |->
      (cmd.res_status == qpht_pkg::ST_INSERTED) || (cmd.res_status == qpht_pkg::ST_FOUND))
    else $error("slot reported with a miss status");

endmodule
